@@ hw/rtl/coalescing_request_ring_queue_core_assert.svh @@
// Assertion macros shared by the queue RTL.
`ifndef COALESCING_REQUEST_RING_QUEUE_CORE_ASSERT_SVH
`define COALESCING_REQUEST_RING_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CRQ_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("coalescing queue check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define CRQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("coalescing queue check failed");

`endif

@@ hw/rtl/crq_pkg.sv @@
package crq_pkg;

	localparam int ID_FIELD_W = 8;
	localparam int VOL_W      = 8;
	localparam int STATUS_W   = 3;
	localparam int COUNT_W    = 4;

	localparam logic [VOL_W-1:0] VOL_FULL = 8'd128;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_MERGED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_POPPED   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

	typedef struct packed {
		logic                  cmd;
		logic [ID_FIELD_W-1:0] sound_id;
		logic [VOL_W-1:0]      req_volume;
	} crq_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [ID_FIELD_W-1:0] out_id;
		logic [VOL_W-1:0]      out_volume;
		logic [COUNT_W-1:0]    pending_count;
	} crq_res_t;

	typedef struct packed {
		logic clear;
		logic step;
		logic push;
		logic merge_en;
		logic in_region;
		logic at_head;
		logic at_tail;
	} crq_tap_ctl_t;

endpackage

@@ hw/rtl/coalescing_request_ring_queue_core.sv @@
// Channel   Handshake          Payload
// request   start / busy       req: cmd, sound_id, req_volume
// result    done (one cycle)   result: status, out_id, out_volume, pending_count
//
// Every item, push or pop, raises done once the scan state and the commit state after it have passed.
// The entries circulate once around the ring of cells, one cell per cycle,
// past a single compare tap; the commit state then updates the head and tail pointers.
// Reset clears the head and tail pointers, so the queue starts empty.
// Busy stays high until the done cycle, so no new item is accepted while one is in its scan or commit state.
`include "coalescing_request_ring_queue_core_assert.svh"

module coalescing_request_ring_queue_core
	import crq_pkg::*;
#(
	parameter int QUEUE_SLOTS = 16,
	parameter int ID_BITS     = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  crq_req_t req,
	output logic     done,
	output crq_res_t result
);

	localparam int IDX_W  = $clog2(QUEUE_SLOTS);
	localparam int CNT_W  = IDX_W + 1;
	localparam int KEEP_W = (ID_BITS < ID_FIELD_W) ? ID_BITS : ID_FIELD_W;
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(QUEUE_SLOTS - 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]       state_q;
	logic [IDX_W-1:0] head_q, tail_q, k_q;
	logic [IDX_W-1:0] head_d, tail_d, head_inc, tail_inc;
	logic [CNT_W-1:0] cnt_d;
	logic             cmd_q, ok_q;
	logic [KEEP_W-1:0] id_q;
	logic [VOL_W-1:0]  vol_q, vol_sat;
	logic             done_q;
	crq_res_t         res_q, res_d;
	logic             accept;

	crq_tap_ctl_t     tap_ctl;
	logic [KEEP_W-1:0] tap_out_id, pop_id;
	logic [VOL_W-1:0]  tap_out_vol, pop_vol;
	logic             matched;

	logic [KEEP_W-1:0] cell_id  [QUEUE_SLOTS];
	logic [VOL_W-1:0]  cell_vol [QUEUE_SLOTS];

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign vol_sat = (req.req_volume > VOL_FULL) ? VOL_FULL : req.req_volume;

	assign head_inc = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == LAST_SLOT) ? '0 : tail_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_DONE);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SCAN;
						k_q     <= '0;
					end
				end
				S_SCAN: begin
					k_q <= (k_q == LAST_SLOT) ? '0 : k_q + 1'b1;
					if (k_q == LAST_SLOT) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					head_q  <= head_d;
					tail_q  <= tail_d;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.cmd;
			id_q  <= req.sound_id[KEEP_W-1:0];
			vol_q <= vol_sat;
			ok_q  <= (tail_inc != head_q);
		end
		if (state_q == S_DONE) begin
			res_q <= res_d;
		end
	end

	always_comb begin
		tap_ctl.clear     = accept;
		tap_ctl.step      = (state_q == S_SCAN);
		tap_ctl.push      = (state_q == S_SCAN) && (cmd_q == CMD_PUSH);
		tap_ctl.merge_en  = ok_q;
		tap_ctl.at_head   = (k_q == head_q);
		tap_ctl.at_tail   = (k_q == tail_q);
		tap_ctl.in_region = (head_q <= tail_q) ? ((k_q >= head_q) && (k_q < tail_q))
		                                       : ((k_q >= head_q) || (k_q < tail_q));
	end

	crq_tap #(.ID_W(KEEP_W)) u_tap (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (tap_ctl),
		.req_id  (id_q),
		.req_vol (vol_q),
		.in_id   (cell_id[0]),
		.in_vol  (cell_vol[0]),
		.out_id  (tap_out_id),
		.out_vol (tap_out_vol),
		.matched (matched),
		.pop_id  (pop_id),
		.pop_vol (pop_vol)
	);

	for (genvar i = 0; i < QUEUE_SLOTS; i++) begin : g_cell
		if (i == QUEUE_SLOTS - 1) begin : g_wrap
			crq_cell #(.ID_W(KEEP_W)) u_cell (
				.clk   (clk),
				.shift (tap_ctl.step),
				.d_id  (tap_out_id),
				.d_vol (tap_out_vol),
				.q_id  (cell_id[i]),
				.q_vol (cell_vol[i])
			);
		end else begin : g_link
			crq_cell #(.ID_W(KEEP_W)) u_cell (
				.clk   (clk),
				.shift (tap_ctl.step),
				.d_id  (cell_id[i+1]),
				.d_vol (cell_vol[i+1]),
				.q_id  (cell_id[i]),
				.q_vol (cell_vol[i])
			);
		end
	end

	always_comb begin
		head_d            = head_q;
		tail_d            = tail_q;
		res_d.out_id      = '0;
		res_d.out_volume  = '0;
		if (cmd_q == CMD_PUSH) begin
			if (!ok_q) begin
				res_d.status = ST_DROPPED;
			end else if (matched) begin
				res_d.status = ST_MERGED;
			end else begin
				res_d.status = ST_APPENDED;
				tail_d       = tail_inc;
			end
		end else begin
			if (head_q == tail_q) begin
				res_d.status = ST_EMPTY;
			end else begin
				res_d.status     = ST_POPPED;
				res_d.out_id     = ID_FIELD_W'(pop_id);
				res_d.out_volume = pop_vol;
				head_d           = head_inc;
			end
		end
		cnt_d = (tail_d >= head_d) ? ({1'b0, tail_d} - {1'b0, head_d})
		                           : ({1'b0, tail_d} + CNT_W'(QUEUE_SLOTS) - {1'b0, head_d});
		res_d.pending_count = COUNT_W'(cnt_d);
	end

	assign done   = done_q;
	assign result = res_q;

	`CRQ_ASSERT_IMP(a_done_idle, done_q, state_q == S_IDLE)
	`CRQ_ASSERT_NEXT(a_accept_busy, accept, state_q == S_SCAN)
	`CRQ_ASSERT_NEXT(a_scan_ends, (state_q == S_SCAN) && (k_q == LAST_SLOT), state_q == S_DONE)
	`CRQ_ASSERT_IMP(a_append_nonempty, done_q && (res_q.status == ST_APPENDED), tail_q != head_q)
	`CRQ_ASSERT_IMP(a_status_range, done_q, res_q.status <= ST_EMPTY)

endmodule

@@ hw/rtl/crq_cell.sv @@
module crq_cell
	import crq_pkg::*;
#(
	parameter int ID_W = 8
) (
	input  logic             clk,
	input  logic             shift,
	input  logic [ID_W-1:0]  d_id,
	input  logic [VOL_W-1:0] d_vol,
	output logic [ID_W-1:0]  q_id,
	output logic [VOL_W-1:0] q_vol
);

	logic [ID_W-1:0]  id_q;
	logic [VOL_W-1:0] vol_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			id_q  <= d_id;
			vol_q <= d_vol;
		end
	end

	assign q_id  = id_q;
	assign q_vol = vol_q;

endmodule

@@ hw/rtl/crq_tap.sv @@
module crq_tap
	import crq_pkg::*;
#(
	parameter int ID_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  crq_tap_ctl_t     ctl,
	input  logic [ID_W-1:0]  req_id,
	input  logic [VOL_W-1:0] req_vol,
	input  logic [ID_W-1:0]  in_id,
	input  logic [VOL_W-1:0] in_vol,
	output logic [ID_W-1:0]  out_id,
	output logic [VOL_W-1:0] out_vol,
	output logic             matched,
	output logic [ID_W-1:0]  pop_id,
	output logic [VOL_W-1:0] pop_vol
);

	logic             hit;
	logic             matched_q;
	logic [ID_W-1:0]  pop_id_q;
	logic [VOL_W-1:0] pop_vol_q;

	assign hit = ctl.push && ctl.merge_en && ctl.in_region && (in_id == req_id);

	always_comb begin
		out_id  = in_id;
		out_vol = in_vol;
		if (ctl.push && ctl.at_tail) begin
			out_id  = req_id;
			out_vol = req_vol;
		end else if (hit && (req_vol > in_vol)) begin
			out_vol = req_vol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matched_q <= 1'b0;
		end else if (ctl.clear) begin
			matched_q <= 1'b0;
		end else if (ctl.step && hit) begin
			matched_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step && !ctl.push && ctl.at_head) begin
			pop_id_q  <= in_id;
			pop_vol_q <= in_vol;
		end
	end

	assign matched = matched_q;
	assign pop_id  = pop_id_q;
	assign pop_vol = pop_vol_q;

endmodule

@@ tb/tb_coalescing_request_ring_queue_core.sv @@
`timescale 1ns / 1ps

module tb_coalescing_request_ring_queue_core;
	import crq_pkg::*;

	localparam int SLOTS        = 16;
	localparam int RANDOM_ITEMS = 1250;
	localparam int DRAIN_CYCLES = 2 * (SLOTS + 2) + 4;

	typedef struct {
		crq_req_t item;
		bit       typed;
		crq_res_t want;
	} plan_row_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	crq_req_t req = '0;
	logic     busy;
	logic     done;
	crq_res_t result;

	logic [ID_FIELD_W-1:0] shadow_ids [SLOTS];
	logic [VOL_W-1:0]      shadow_vols [SLOTS];
	int                    shadow_head = 0;
	int                    shadow_tail = 0;

	crq_res_t  awaited_results [$];
	int        mismatches = 0;
	plan_row_t plan [25];

	coalescing_request_ring_queue_core #(
		.QUEUE_SLOTS(SLOTS),
		.ID_BITS(8)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.result(result)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic crq_res_t queue_outcome(crq_req_t r);
		crq_res_t          res;
		logic [VOL_W-1:0]  vol;
		int                i;
		bit                found;
		res = '0;
		found = 1'b0;
		if (r.cmd == CMD_PUSH) begin
			vol = (r.req_volume > VOL_FULL) ? VOL_FULL : r.req_volume;
			if ((shadow_tail + 1) % SLOTS == shadow_head) begin
				res.status = ST_DROPPED;
			end else begin
				i = shadow_head;
				while (i != shadow_tail && !found) begin
					if (shadow_ids[i] == r.sound_id) begin
						found = 1'b1;
						if (vol > shadow_vols[i])
							shadow_vols[i] = vol;
					end else begin
						i = (i + 1) % SLOTS;
					end
				end
				if (found) begin
					res.status = ST_MERGED;
				end else begin
					shadow_ids[shadow_tail] = r.sound_id;
					shadow_vols[shadow_tail] = vol;
					shadow_tail = (shadow_tail + 1) % SLOTS;
					res.status = ST_APPENDED;
				end
			end
		end else begin
			if (shadow_head == shadow_tail) begin
				res.status = ST_EMPTY;
			end else begin
				res.out_id = shadow_ids[shadow_head];
				res.out_volume = shadow_vols[shadow_head];
				shadow_head = (shadow_head + 1) % SLOTS;
				res.status = ST_POPPED;
			end
		end
		res.pending_count = COUNT_W'((shadow_tail + SLOTS - shadow_head) % SLOTS);
		return res;
	endfunction

	function automatic plan_row_t row(logic cmd, logic [7:0] id, logic [7:0] vol, bit typed,
			logic [STATUS_W-1:0] st, logic [7:0] oid, logic [7:0] ovol,
			logic [COUNT_W-1:0] cnt);
		plan_row_t r;
		r.item = '{cmd: cmd, sound_id: id, req_volume: vol};
		r.typed = typed;
		r.want = '{status: st, out_id: oid, out_volume: ovol, pending_count: cnt};
		return r;
	endfunction

	// Called at a rising edge; returns at the edge where the item is accepted.
	task automatic issue_request(crq_req_t item, bit typed, crq_res_t want, int gap);
		crq_res_t predicted;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= item;
		do @(posedge clk); while (busy !== 1'b0);
		predicted = queue_outcome(item);
		awaited_results.push_back(typed ? want : predicted);
	endtask

	always @(posedge clk) begin
		crq_res_t exp_res;
		if (arst_n && done === 1'b1) begin
			if (awaited_results.size() == 0) begin
				$error("result with no item outstanding: status %0d", result.status);
				mismatches++;
			end else begin
				exp_res = awaited_results.pop_front();
				if (result.status !== exp_res.status) begin
					$error("status: expected %0d, actual %0d", exp_res.status, result.status);
					mismatches++;
				end
				if (result.out_id !== exp_res.out_id) begin
					$error("out_id: expected %0d, actual %0d", exp_res.out_id, result.out_id);
					mismatches++;
				end
				if (result.out_volume !== exp_res.out_volume) begin
					$error("out_volume: expected %0d, actual %0d",
						exp_res.out_volume, result.out_volume);
					mismatches++;
				end
				if (result.pending_count !== exp_res.pending_count) begin
					$error("pending_count: expected %0d, actual %0d",
						exp_res.pending_count, result.pending_count);
					mismatches++;
				end
			end
		end
	end

	initial begin
		crq_req_t item;
		int       push_pct;
		bit       burst;
		int       gap;

		plan[0]  = row(CMD_POP,  8'h00, 8'h00, 1, ST_EMPTY,    8'h00, 8'h00, 4'd0);
		plan[1]  = row(CMD_PUSH, 8'h00, 8'h00, 1, ST_APPENDED, 8'h00, 8'h00, 4'd1);
		plan[2]  = row(CMD_PUSH, 8'hFF, 8'hFF, 1, ST_APPENDED, 8'h00, 8'h00, 4'd2);
		plan[3]  = row(CMD_PUSH, 8'hFF, 8'h05, 1, ST_MERGED,   8'h00, 8'h00, 4'd2);
		plan[4]  = row(CMD_PUSH, 8'h00, 8'h80, 1, ST_MERGED,   8'h00, 8'h00, 4'd2);
		plan[5]  = row(CMD_POP,  8'h00, 8'h00, 1, ST_POPPED,   8'h00, 8'h80, 4'd1);
		plan[6]  = row(CMD_POP,  8'hFF, 8'hFF, 1, ST_POPPED,   8'hFF, 8'h80, 4'd0);
		plan[7]  = row(CMD_POP,  8'h00, 8'h00, 1, ST_EMPTY,    8'h00, 8'h00, 4'd0);
		plan[8]  = row(CMD_PUSH, 8'h01, 8'h81, 0, ST_APPENDED, 8'h00, 8'h00, 4'd0);
		plan[9]  = row(CMD_PUSH, 8'h02, 8'h40, 0, ST_APPENDED, 8'h00, 8'h00, 4'd0);
		plan[10] = row(CMD_PUSH, 8'h04, 8'h01, 0, ST_APPENDED, 8'h00, 8'h00, 4'd0);
		plan[11] = row(CMD_PUSH, 8'h08, 8'h7F, 0, ST_APPENDED, 8'h00, 8'h00, 4'd0);
		plan[12] = row(CMD_PUSH, 8'h10, 8'h80, 0, ST_APPENDED, 8'h00, 8'h00, 4'd0);
		plan[13] = row(CMD_PUSH, 8'h20, 8'hC8, 0, ST_APPENDED, 8'h00, 8'h00, 4'd0);
		plan[14] = row(CMD_PUSH, 8'h40, 8'h33, 0, ST_APPENDED, 8'h00, 8'h00, 4'd0);
		plan[15] = row(CMD_PUSH, 8'h80, 8'h00, 0, ST_APPENDED, 8'h00, 8'h00, 4'd0);
		plan[16] = row(CMD_PUSH, 8'h7F, 8'h55, 0, ST_APPENDED, 8'h00, 8'h00, 4'd0);
		plan[17] = row(CMD_PUSH, 8'hBF, 8'h2A, 0, ST_APPENDED, 8'h00, 8'h00, 4'd0);
		plan[18] = row(CMD_PUSH, 8'hDF, 8'h10, 0, ST_APPENDED, 8'h00, 8'h00, 4'd0);
		plan[19] = row(CMD_PUSH, 8'hEF, 8'h08, 0, ST_APPENDED, 8'h00, 8'h00, 4'd0);
		plan[20] = row(CMD_PUSH, 8'hF7, 8'h04, 0, ST_APPENDED, 8'h00, 8'h00, 4'd0);
		plan[21] = row(CMD_PUSH, 8'hFB, 8'h02, 0, ST_APPENDED, 8'h00, 8'h00, 4'd0);
		plan[22] = row(CMD_PUSH, 8'hFD, 8'h7E, 0, ST_APPENDED, 8'h00, 8'h00, 4'd0);
		plan[23] = row(CMD_PUSH, 8'h01, 8'h80, 1, ST_DROPPED,  8'h00, 8'h00, 4'd15);
		plan[24] = row(CMD_PUSH, 8'h33, 8'h80, 1, ST_DROPPED,  8'h00, 8'h00, 4'd15);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (plan[k])
			issue_request(plan[k].item, plan[k].typed, plan[k].want, $urandom_range(0, 18));

		// Each chunk picks filling, draining or mixed traffic at random so the
		// queue spends time both full and empty; a small identifier pool makes
		// merges common.
		push_pct = 50;
		burst = 1'b0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0) begin
				case ($urandom_range(0, 2))
					0: push_pct = 85;
					1: push_pct = 20;
					default: push_pct = 55;
				endcase
				burst = ($urandom_range(0, 3) == 0);
			end
			item.cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
			item.sound_id = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, 23))
				: 8'($urandom_range(0, 255));
			item.req_volume = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 128))
				: 8'($urandom_range(129, 255));
			gap = burst ? 0 : $urandom_range(0, 18);
			issue_request(item, 1'b0, '0, gap);
		end
		start <= 1'b0;

		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
